// ===== rtl/core/fpdaf_pkg.sv =====
// Shared constants and elaboration helpers for the fixed-point decimal ASCII formatter.
`default_nettype none
package fpdaf_pkg;

    localparam int MAG_W = 32;

    localparam int BCD_STEPS_PER_STAGE = 8;
    localparam int BCD_STAGES = MAG_W / BCD_STEPS_PER_STAGE;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam int RADIX = 10;

    // digits shown: one position goes to the point when it lands inside the string
    function automatic int digit_count(input int frac_digits, input int total_chars);
        int n;
        begin
            n = total_chars;
            if (frac_digits < total_chars && frac_digits >= 0)
            begin
                n = total_chars - 1;
            end
            return n;
        end
    endfunction

    // largest magnitude the digit positions can show: 10^ndig - 1
    function automatic logic [63:0] max_magnitude(input int ndig);
        logic [63:0] m;
        begin
            m = 64'd1;
            for (int i = 0; i < ndig; i++)
            begin
                m = m * 64'(RADIX);
            end
            return m - 64'd1;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/fpdaf_mag_stage.sv =====
// Input stage: absolute value and saturation to the displayable range.
`default_nettype none
module fpdaf_mag_stage #(
    parameter int NDIG = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [fpdaf_pkg::MAG_W-1:0]   in_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [fpdaf_pkg::MAG_W-1:0]        out_mag
);

    localparam logic [63:0] LIM = fpdaf_pkg::max_magnitude(NDIG);

    logic                         valid_reg;
    logic                         valid_next;
    logic [fpdaf_pkg::MAG_W-1:0]  mag_reg;
    logic [fpdaf_pkg::MAG_W-1:0]  mag_abs;
    logic [fpdaf_pkg::MAG_W-1:0]  mag_sat;

    // most negative input wraps to 2^31 as an unsigned magnitude
    assign mag_abs = in_value[fpdaf_pkg::MAG_W-1] ? (~in_value + 1'b1) : in_value;

    always_comb
    begin
        if ({32'd0, mag_abs} > LIM)
        begin
            mag_sat = LIM[fpdaf_pkg::MAG_W-1:0];
        end
        else
        begin
            mag_sat = mag_abs;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mag_reg <= mag_sat;
        end
    end

    assign out_valid = valid_reg;
    assign out_mag   = mag_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fpdaf_bcd_stage.sv =====
// One slice of the shift-and-add-3 binary to BCD converter.
`default_nettype none
module fpdaf_bcd_stage #(
    parameter int NDIG = 6
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire logic [4*NDIG+fpdaf_pkg::MAG_W-1:0]      in_word,
    output logic                                         out_valid,
    input  wire logic                                    out_ready,
    output logic [4*NDIG+fpdaf_pkg::MAG_W-1:0]           out_word
);

    localparam int W = 4 * NDIG + fpdaf_pkg::MAG_W;

    logic          valid_reg;
    logic          valid_next;
    logic [W-1:0]  word_reg;
    logic [W-1:0]  word_next;

    // {bcd, binary}: adjust each digit, then shift one binary bit into the digits
    always_comb
    begin
        word_next = in_word;
        for (int s = 0; s < fpdaf_pkg::BCD_STEPS_PER_STAGE; s++)
        begin
            for (int d = 0; d < NDIG; d++)
            begin
                if (word_next[fpdaf_pkg::MAG_W + 4*d +: 4] >= 4'd5)
                begin
                    word_next[fpdaf_pkg::MAG_W + 4*d +: 4] =
                        word_next[fpdaf_pkg::MAG_W + 4*d +: 4] + 4'd3;
                end
            end
            word_next = word_next << 1;
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule
`default_nettype wire

// ===== rtl/core/fpdaf_serializer.sv =====
// Character serializer: BCD digits plus point, one ASCII beat per cycle while the sink is ready.
`default_nettype none
module fpdaf_serializer #(
    parameter int FRACTION_DIGITS = 3,
    parameter int TOTAL_CHARS     = 7,
    parameter int NDIG            = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [4*NDIG-1:0]    in_bcd,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_char,
    output logic                      out_last
);

    localparam int  POS_W     = $clog2(TOTAL_CHARS);
    localparam bit  HAS_POINT = (FRACTION_DIGITS < TOTAL_CHARS);
    localparam int  POINT_POS = HAS_POINT ? (TOTAL_CHARS - 1 - FRACTION_DIGITS) : 0;
    localparam int  BCD_W     = 4 * NDIG;

    logic               busy_reg;
    logic               busy_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic               oval_reg;
    logic               oval_next;
    logic [7:0]         char_reg;
    logic               last_reg;

    logic               out_load;
    logic               emit;
    logic               is_point;
    logic               is_last;
    logic               buf_free;
    logic [7:0]         char_cur;

    assign out_load = !oval_reg || out_ready;
    assign emit     = busy_reg && out_load;
    assign is_point = HAS_POINT && (pos_reg == POS_W'(POINT_POS));
    assign is_last  = (pos_reg == POS_W'(TOTAL_CHARS - 1));
    assign buf_free = !busy_reg || (emit && is_last);
    assign in_ready = buf_free;

    // top digit is always the next one out; the point does not consume a digit
    assign char_cur = is_point ? fpdaf_pkg::CHAR_POINT
                               : (fpdaf_pkg::CHAR_ZERO + {4'd0, bcd_reg[BCD_W-1 -: 4]});

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        bcd_next  = bcd_reg;
        if (in_valid && buf_free)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            bcd_next  = in_bcd;
        end
        else if (emit)
        begin
            busy_next = !is_last;
            // back to the first position once the number is done
            pos_next  = is_last ? '0 : (pos_reg + 1'b1);
            bcd_next  = is_point ? bcd_reg : (bcd_reg << 4);
        end
    end

    assign oval_next = out_load ? busy_reg : oval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
            oval_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        if (emit)
        begin
            char_reg <= char_cur;
            last_reg <= is_last;
        end
    end

    assign out_valid = oval_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg <= POS_W'(TOTAL_CHARS - 1)))
        else $error("serializer position past last character");

    a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pos_reg == '0) || $past(emit))
        else $error("idle serializer holds a stale position");

    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        oval_reg |-> (char_reg == fpdaf_pkg::CHAR_POINT && HAS_POINT) ||
                     (char_reg >= fpdaf_pkg::CHAR_ZERO && char_reg <= 8'h39))
        else $error("output beat is neither digit nor point");

endmodule
`default_nettype wire

// ===== rtl/core/fixed_point_decimal_ascii_formatter.sv =====
// Top level of the fixed-point decimal ASCII formatter.
// Each signed input beat (a number in units of 10^-FRACTION_DIGITS) becomes
// TOTAL_CHARS ASCII beats, most significant first: integer digits with
// leading zeros, a '.', then FRACTION_DIGITS fraction digits ("DDD.ddd" by
// default). The sign is dropped; magnitudes beyond what the digit positions
// can show (999999 by default, including the most negative input) come out
// as all nines. If FRACTION_DIGITS is not below TOTAL_CHARS no point is
// emitted. m_tlast marks the final character of each number. Rate: one
// character per cycle while m_tready holds; a new number is taken as the
// previous one's last character goes out, set by the serializer's single
// output beat per cycle. The pipeline (magnitude stage, four binary-to-BCD
// stages of eight shift-add steps each, serializer, output register)
// buffers several numbers, so input beats are taken back to back until it
// fills; a beat's first character follows it through all these registers.
`default_nettype none
module fixed_point_decimal_ascii_formatter #(
    parameter int FRACTION_DIGITS = 3,
    parameter int TOTAL_CHARS     = 7
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // [31:0] value (signed)
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,   // [7:0] ascii_char
    output logic              m_tlast    // last_char
);

    localparam int NDIG  = fpdaf_pkg::digit_count(FRACTION_DIGITS, TOTAL_CHARS);
    localparam int BCD_W = 4 * NDIG;
    localparam int W     = BCD_W + fpdaf_pkg::MAG_W;
    localparam int NST   = fpdaf_pkg::BCD_STAGES;

    logic                             mag_valid;
    logic                             mag_ready;
    logic [fpdaf_pkg::MAG_W-1:0]      mag;

    logic                             pipe_valid [0:NST];
    logic                             pipe_ready [0:NST];
    logic [W-1:0]                     pipe_word  [0:NST];

    // magnitude and clamp
    fpdaf_mag_stage #(
        .NDIG (NDIG)
    ) u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .out_valid (mag_valid),
        .out_ready (mag_ready),
        .out_mag   (mag)
    );

    // digits start cleared, binary value in the low bits
    assign pipe_valid[0] = mag_valid;
    assign mag_ready     = pipe_ready[0];
    assign pipe_word[0]  = {{BCD_W{1'b0}}, mag};

    for (genvar g = 0; g < NST; g++)
    begin : g_bcd
        fpdaf_bcd_stage #(
            .NDIG (NDIG)
        ) u_bcd (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[g]),
            .in_ready  (pipe_ready[g]),
            .in_word   (pipe_word[g]),
            .out_valid (pipe_valid[g+1]),
            .out_ready (pipe_ready[g+1]),
            .out_word  (pipe_word[g+1])
        );
    end

    // all binary bits have shifted through; digits sit in the upper bits
    fpdaf_serializer #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .TOTAL_CHARS     (TOTAL_CHARS),
        .NDIG            (NDIG)
    ) u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid[NST]),
        .in_ready  (pipe_ready[NST]),
        .in_bcd    (pipe_word[NST][W-1 -: BCD_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the fixed-point decimal ASCII formatter.
`default_nettype none

// Scoreboard: turns each accepted number into its seven expected characters
// and compares every output beat against the oldest one waiting.
class char_scoreboard;
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    localparam int FRAC_DIGITS = 3;
    localparam int NUM_CHARS   = 7;
    localparam logic [32:0] MAX_SHOWN = 33'd999999;

    char_beat_t expected_chars[$];
    int errors;
    int numbers_noted;
    int chars_checked;
    int saturated;

    function new();
        errors        = 0;
        numbers_noted = 0;
        chars_checked = 0;
        saturated     = 0;
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

    // absolute value, clamp to 999.999, split into digits around the point
    function void note_number(input logic [31:0] value);
        logic [32:0] mag;
        logic [7:0]  chars[NUM_CHARS];
        char_beat_t  beat;
        begin
            mag = value[31] ? ({1'b0, ~value} + 33'd1) : {1'b0, value};
            if (mag > MAX_SHOWN)
            begin
                mag = MAX_SHOWN;
                saturated++;
            end
            for (int i = 0; i < NUM_CHARS; i++)
            begin
                if (i == FRAC_DIGITS)
                begin
                    chars[i] = fpdaf_pkg::CHAR_POINT;
                end
                else
                begin
                    chars[i] = fpdaf_pkg::CHAR_ZERO + 8'(mag % 33'd10);
                    mag      = mag / 33'd10;
                end
            end
            for (int i = NUM_CHARS - 1; i >= 0; i--)
            begin
                beat.ch   = chars[i];
                beat.last = (i == 0);
                expected_chars.push_back(beat);
            end
            numbers_noted++;
        end
    endfunction

    task report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    task check_char(input logic [7:0] ch, input logic last);
        char_beat_t exp_beat;
        begin
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("unexpected char 0x%02h last=%0b", ch, last));
            end
            else
            begin
                exp_beat = expected_chars.pop_front();
                if (ch !== exp_beat.ch)
                begin
                    report($sformatf("char 0x%02h, expected 0x%02h", ch, exp_beat.ch));
                end
                if (last !== exp_beat.last)
                begin
                    report($sformatf("tlast %0b, expected %0b", last, exp_beat.last));
                end
            end
        end
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limit: ~460 numbers at worst (longest send gap, 7 chars each given the
    // longest sink stall), plus the long hold, stay inside CYCLE_LIMIT.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 20;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] ascii_char
    logic        m_tlast;        // last_char

    char_scoreboard sb = new();

    int  cycle_count     = 0;
    int  input_stalls    = 0;
    int  directed_count  = 0;
    bit  hold_request    = 1'b0;   // sender asks the sink for one long hold-off
    bit  sender_burst    = 1'b0;

    fixed_point_decimal_ascii_formatter DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),      // [31:0] value (signed)
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),      // [7:0] ascii_char
        .m_tlast  (m_tlast)       // last_char
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d chars outstanding",
                     cycle_count, sb.pending());
            $display("FAILURE");
            $finish;
        end
    end

    // Beat monitors: both sample the values settled before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                sb.note_number(s_tdata);
            end
            if (s_tvalid && !s_tready)
            begin
                input_stalls <= input_stalls + 1;
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_char(m_tdata, m_tlast);
            end
        end
    end

    // One number per call; idle for the given gap first, then hold until taken.
    task send_number(input logic [31:0] value, input int gap);
        begin
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= value;
            do @(posedge clk); while (!s_tready);
        end
    endtask

    function int next_gap();
        return sender_burst ? 0 : int'($urandom_range(0, 17));
    endfunction

    // Mostly in-range values; some small, some huge (saturate), some right at
    // the saturation boundary.
    function logic [31:0] pick_value();
        int sel;
        int v;
        begin
            sel = int'($urandom_range(0, 9));
            if (sel <= 5)
            begin
                v = int'($urandom_range(0, 1999998)) - 999999;
            end
            else if (sel <= 7)
            begin
                v = int'($urandom_range(0, 19998)) - 9999;
            end
            else if (sel == 8)
            begin
                v = int'($urandom);
            end
            else
            begin
                v = int'($urandom_range(999990, 1000010));
                if ($urandom_range(0, 1))
                begin
                    v = -v;
                end
            end
            return v;
        end
    endfunction

    // Sink: per-beat random stall, stall-free stretches, one long hold-off.
    initial
    begin : sink
        int stall;
        int beats;
        beats = 0;
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            else if ((beats / 60) % 3 == 1)
            begin
                stall = 0;
            end
            else
            begin
                stall = int'($urandom_range(0, 17));
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            beats++;
        end
    end

    // Main sequence
    initial
    begin : stimulus
        logic [31:0] directed_values[$];
        directed_values = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, 32'd999, 32'd1000,
            32'd123456, -32'sd123456, 32'd999998, 32'd999999, -32'sd999999,
            32'd1000000, -32'sd1000000, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h5555_5555, 32'hAAAA_AAAA, 32'd100000, -32'sd5, 32'hFFFF_0000
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, sign, digit rollovers, saturation edge, extremes
        foreach (directed_values[i])
        begin
            send_number(directed_values[i], (i % 4 == 0) ? 0 : int'($urandom_range(0, 17)));
            directed_count++;
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_burst = ((n / 32) % 2 == 1);
            if (n == 100)
            begin
                // long sink hold while the source keeps pushing back to back
                hold_request = 1'b1;
                for (int k = 0; k < 40; k++)
                begin
                    send_number(pick_value(), 0);
                end
            end
            else if (n == 250)
            begin
                // source pause until the pipeline has drained completely;
                // one edge first so the last accepted number is noted
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
                send_number(pick_value(), 0);
            end
            else
            begin
                send_number(pick_value(), next_gap());
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Formatted %0d numbers (%0d directed, %0d clamped to 999.999), %0d chars",
                 sb.numbers_noted, directed_count, sb.saturated, sb.chars_checked);
        $display("Random stalls on both ports, %0d input backpressure cycles, %0d errors",
                 input_stalls, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
